// File: rtl/lpmr_pkg.sv
// Shared types and codes for the length-prefixed message ring.
// Holds item and result records, status codes and parameter defaults.
// No dependencies.
package lpmr_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 12;
    localparam int STATUS_W = 3;

    // Defaults for the top-level parameters
    localparam int RING_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 8;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_WRITE_OK = 3'd0;
    localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ZERO_LEN = 3'd6;

    typedef struct packed {
        logic              operation;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  message_length;
        logic [LEN_W-1:0]  reader_limit;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_byte_out;
        logic                last_of_message;
        logic [LEN_W-1:0]    length_out;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// File: rtl/lpmr_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Width and depth set by parameters; no dependencies.
module lpmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic                     re,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on we, register read data on re
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/lpmr_ctrl.sv
// Sequencer of the message ring: pointers, byte counters and RAM accesses.
// Depends on lpmr_pkg; drives one lpmr_ram port from the top level.
module lpmr_ctrl
    import lpmr_pkg::*;
#(
    parameter int RING_BYTES   = RING_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  item_t                         in_item,
    input  logic                          slot_free,
    output logic                          res_push,
    output result_t                       res,
    output logic [$clog2(RING_BYTES)-1:0] ram_addr,
    output logic                          ram_we,
    output logic                          ram_re,
    output logic [BYTE_W-1:0]             ram_wdata,
    input  logic [BYTE_W-1:0]             ram_rdata
);

    localparam int PTR_W  = $clog2(RING_BYTES);
    localparam int CNT_W  = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 2;
    localparam int HIDX_W = $clog2(HEADER_BYTES);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_HDR_W = 2'd2;
    localparam logic [1:0] S_RD_H1 = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [PTR_W-1:0]  cwp_reg, cwp_next;
    logic [PTR_W-1:0]  wwp_reg, wwp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [LEN_W-1:0]  wbl_reg, wbl_next;
    logic [LEN_W-1:0]  rbl_reg, rbl_next;
    logic [HIDX_W-1:0] hidx_reg, hidx_next;
    logic              rd_open_reg, rd_open_next;
    item_t             item_reg, item_next;
    logic [BYTE_W-1:0] lo_reg, lo_next;

    logic [PTR_W-1:0]  cwp_inc, wwp_inc, rp_inc, rp_hdr;
    logic [PTR_W:0]    rp_sum;
    logic [PTR_W-1:0]  used;
    logic [CNT_W-1:0]  room, need;
    logic              too_long, no_room;
    logic [2*BYTE_W-1:0] hdr_len;
    logic [BYTE_W-1:0] hdr_byte;
    logic              res_valid;
    logic              stall;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    // Pointer steps with wraparound
    assign cwp_inc = ptr_inc(cwp_reg);
    assign wwp_inc = ptr_inc(wwp_reg);
    assign rp_inc  = ptr_inc(rp_reg);
    assign rp_sum  = {1'b0, rp_reg} + (PTR_W+1)'(HEADER_BYTES);
    assign rp_hdr  = (rp_sum >= (PTR_W+1)'(RING_BYTES))
                   ? PTR_W'(rp_sum - (PTR_W+1)'(RING_BYTES)) : rp_sum[PTR_W-1:0];

    // Room check for an opening write; one byte stays free
    always_comb
    begin
        if (cwp_reg >= rp_reg)
        begin
            used = cwp_reg - rp_reg;
        end
        else
        begin
            used = PTR_W'({1'b0, cwp_reg} + (PTR_W+1)'(RING_BYTES) - {1'b0, rp_reg});
        end
    end

    assign room     = CNT_W'(RING_BYTES - 1) - CNT_W'(used);
    assign need     = CNT_W'(HEADER_BYTES) + CNT_W'(item_reg.message_length);
    assign too_long = (need > CNT_W'(RING_BYTES - 1));
    assign no_room  = (need > room);

    // Length from the two low header bytes, the second just read
    assign hdr_len  = {ram_rdata, lo_reg};

    // Upper header bytes; the low byte goes out when the message opens
    assign hdr_byte = (hidx_reg == HIDX_W'(1))
                    ? BYTE_W'(item_reg.message_length >> BYTE_W) : '0;

    assign in_ready = (state_reg == S_IDLE);

    // Next-state and datapath
    always_comb
    begin
        state_next   = state_reg;
        cwp_next     = cwp_reg;
        wwp_next     = wwp_reg;
        rp_next      = rp_reg;
        wbl_next     = wbl_reg;
        rbl_next     = rbl_reg;
        hidx_next    = hidx_reg;
        rd_open_next = rd_open_reg;
        item_next    = item_reg;
        lo_next      = lo_reg;
        res          = '0;
        res_valid    = 1'b0;
        ram_addr     = rp_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_wdata    = item_reg.data_byte;

        unique case (state_reg)
            S_IDLE:
            begin
                // Take the item and fetch the byte at the read pointer ahead
                if (in_valid)
                begin
                    item_next  = in_item;
                    ram_re     = 1'b1;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (item_reg.operation == OP_WRITE)
                begin
                    if (wbl_reg != '0)
                    begin
                        // Store a data byte; commit after the last one
                        ram_addr   = wwp_reg;
                        ram_we     = 1'b1;
                        wwp_next   = wwp_inc;
                        wbl_next   = wbl_reg - 1'b1;
                        res_valid  = 1'b1;
                        res.status = ST_WRITE_OK;
                        if (wbl_reg == LEN_W'(1))
                        begin
                            cwp_next            = wwp_inc;
                            res.last_of_message = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                    else if (too_long)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_TOO_LONG;
                        state_next = S_IDLE;
                    end
                    else if (no_room)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_NO_ROOM;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // Open the message at the committed pointer
                        ram_addr   = cwp_reg;
                        ram_we     = 1'b1;
                        ram_wdata  = item_reg.message_length[BYTE_W-1:0];
                        wwp_next   = cwp_inc;
                        hidx_next  = HIDX_W'(1);
                        state_next = S_HDR_W;
                    end
                end
                else
                begin
                    if (rbl_reg != '0)
                    begin
                        // Deliver a data byte fetched in the previous cycle
                        res_valid         = 1'b1;
                        res.status        = ST_READ_OK;
                        res.data_byte_out = ram_rdata;
                        rp_next           = rp_inc;
                        rbl_next          = rbl_reg - 1'b1;
                        // The opening read also reports the message length
                        if (rd_open_reg)
                        begin
                            res.length_out = rbl_reg;
                            rd_open_next   = 1'b0;
                        end
                        if (rbl_reg == LEN_W'(1))
                        begin
                            res.last_of_message = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                    else if (cwp_reg == rp_reg)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_EMPTY;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // Hold the low header byte, fetch the next one
                        lo_next    = ram_rdata;
                        ram_addr   = rp_inc;
                        ram_re     = 1'b1;
                        state_next = S_RD_H1;
                    end
                end
            end

            S_HDR_W:
            begin
                ram_addr  = wwp_reg;
                ram_we    = 1'b1;
                ram_wdata = hdr_byte;
                wwp_next  = wwp_inc;
                hidx_next = hidx_reg + 1'b1;
                if (hidx_reg == HIDX_W'(HEADER_BYTES - 1))
                begin
                    if (item_reg.message_length == '0)
                    begin
                        // Header alone: commit at once
                        cwp_next            = wwp_inc;
                        res_valid           = 1'b1;
                        res.status          = ST_WRITE_OK;
                        res.last_of_message = 1'b1;
                        state_next          = S_IDLE;
                    end
                    else
                    begin
                        // Go on to store the item's own data byte
                        wbl_next   = item_reg.message_length;
                        state_next = S_EXEC;
                    end
                end
            end

            S_RD_H1:
            begin
                res.length_out = hdr_len[LEN_W-1:0];
                if (hdr_len > (2*BYTE_W)'(item_reg.reader_limit))
                begin
                    // Leave the message in place
                    res_valid  = 1'b1;
                    res.status = ST_TOO_BIG;
                    state_next = S_IDLE;
                end
                else
                begin
                    rp_next = rp_hdr;
                    if (hdr_len == '0)
                    begin
                        res_valid           = 1'b1;
                        res.status          = ST_ZERO_LEN;
                        res.last_of_message = 1'b1;
                        state_next          = S_IDLE;
                    end
                    else
                    begin
                        // Fetch the first data byte past the header
                        rbl_next     = hdr_len[LEN_W-1:0];
                        rd_open_next = 1'b1;
                        ram_addr     = rp_hdr;
                        ram_re       = 1'b1;
                        state_next   = S_EXEC;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold everything while a result waits for a free output slot
    assign stall    = res_valid & ~slot_free;
    assign res_push = res_valid & slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cwp_reg     <= '0;
            wwp_reg     <= '0;
            rp_reg      <= '0;
            wbl_reg     <= '0;
            rbl_reg     <= '0;
            hidx_reg    <= '0;
            rd_open_reg <= 1'b0;
        end
        else if (!stall)
        begin
            state_reg   <= state_next;
            cwp_reg     <= cwp_next;
            wwp_reg     <= wwp_next;
            rp_reg      <= rp_next;
            wbl_reg     <= wbl_next;
            rbl_reg     <= rbl_next;
            hidx_reg    <= hidx_next;
            rd_open_reg <= rd_open_next;
        end
    end

    // Item and header byte hold
    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            item_reg <= item_next;
            lo_reg   <= lo_next;
        end
    end

endmodule

// File: rtl/length_prefixed_message_ring.sv
// Top level of the length-prefixed message ring: stream ports, output register.
// Depends on lpmr_pkg, lpmr_ctrl and lpmr_ram.
//
// Usage: each transfer on the s_axis side is one byte operation, tuser
// selecting write (0) or read (1); each produces exactly one transfer on the
// m_axis side carrying the byte read, the message length on an opening read,
// the status in tuser and tlast on the byte that ends a message.
// Messages sit in the ring as a HEADER_BYTES little-endian length header and
// their bytes; a message becomes readable only after its last byte is written.
// Steps per item, from the cycle taking the input transfer to the edge
// loading the output register:
//   continuing write or read, empty read, rejected write: the execute state alone;
//   opening read: two header fetches, then the first data fetch, or the two
//   fetches alone when the message is too big for the reader or has zero length;
//   opening write: the HEADER_BYTES header bytes, then the data byte, or the
//   header alone for zero length. The single RAM port, one byte per cycle,
// paces these steps; items are handled one at a time.
// Reset clears pointers and counters; the ring contents need no clearing.
// A stalled receiver holds the result in the output register; one further
// item is accepted and worked up to its result, which then waits.
module length_prefixed_message_ring
    import lpmr_pkg::*;
#(
    parameter int RING_BYTES   = RING_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // data_byte[7:0], message_length[19:8], reader_limit[31:20]
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // data_byte_out[7:0], length_out[19:8], zero[23:20]
    output logic        m_axis_tlast,  // last_of_message
    output logic [2:0]  m_axis_tuser   // status
);

    localparam int PTR_W = $clog2(RING_BYTES);

    item_t             in_item;
    result_t           res;
    logic              res_push;
    logic              slot_free;
    logic [PTR_W-1:0]  ram_addr;
    logic              ram_we;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg;

    // Unpack the input transfer
    assign in_item.operation      = s_axis_tuser;
    assign in_item.data_byte      = s_axis_tdata[7:0];
    assign in_item.message_length = s_axis_tdata[19:8];
    assign in_item.reader_limit   = s_axis_tdata[31:20];

    lpmr_ctrl #(
        .RING_BYTES   (RING_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .slot_free (slot_free),
        .res_push  (res_push),
        .res       (res),
        .ram_addr  (ram_addr),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    lpmr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_BYTES)
    ) u_ring (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .re    (ram_re),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Output register: free when empty or drained this cycle
    assign slot_free = ~out_valid_reg | m_axis_tready;

    always_comb
    begin
        if (res_push)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_res_reg.length_out, out_res_reg.data_byte_out};
    assign m_axis_tlast  = out_res_reg.last_of_message;
    assign m_axis_tuser  = out_res_reg.status;

endmodule

// File: tb/tb.sv
// Self-checking testbench for length_prefixed_message_ring: directed table, then random traffic.
// Holds its own copy of the ring and pointers to predict every result transfer.
// Depends on lpmr_pkg and the length_prefixed_message_ring RTL.
`timescale 1ns / 100ps

module tb;
    import lpmr_pkg::*;

    localparam int RING        = RING_BYTES_DEF;
    localparam int HDR         = HEADER_BYTES_DEF;
    localparam int CYCLE_LIMIT = 500000;

    typedef enum int {MIX_TRAFFIC, FILL_RING, DRAIN_RING} traffic_t;

    // One directed row: the item, whether the result is given here, and that result
    typedef struct packed {
        item_t   it;
        logic    typed;
        result_t want;
    } step_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // data_byte[7:0], message_length[19:8], reader_limit[31:20]
    logic        s_axis_tuser;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // data_byte_out[7:0], length_out[19:8], zero[23:20]
    logic        m_axis_tlast;   // last_of_message
    logic [2:0]  m_axis_tuser;   // status

    // Predicted ring contents and pointers
    logic [BYTE_W-1:0] ring_copy [0:RING-1];
    int                commit_ptr;
    int                work_ptr;
    int                rd_ptr;
    int                wr_left;
    int                rd_left;
    int                refused_for_room;

    result_t awaited_results [$];
    step_t   directed_plan [0:17];
    int      status_tally [0:7];
    int      mismatches;
    int      items_sent;
    int      cycles;
    bit      tx_gaps_on;
    bit      rx_gaps_on;
    bit      quiet_tail;

    length_prefixed_message_ring #(
        .RING_BYTES   (RING),
        .HEADER_BYTES (HDR)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Free bytes, keeping one byte spare so a full ring never reads as empty
    function automatic int ring_room();
        return RING - 1 - ((commit_ptr + RING - rd_ptr) % RING);
    endfunction

    // Assemble the little-endian length header that starts at position p
    function automatic longint header_at(int p);
        longint len;
        len = 0;
        for (int i = 0; i < HDR; i++)
        begin
            len |= longint'(ring_copy[p]) << (8 * i);
            p = (p + 1) % RING;
        end
        return len;
    endfunction

    // Length of the message the next read would open, or -1 if none opens
    function automatic int next_read_length();
        if (rd_left != 0 || commit_ptr == rd_ptr)
            return -1;
        return int'(header_at(rd_ptr));
    endfunction

    // Advance the predicted ring by one accepted item and return its result
    function automatic result_t ring_predict(item_t it);
        result_t r;
        longint  len;
        r = '0;
        if (it.operation == OP_WRITE)
        begin
            if (wr_left == 0)
            begin
                len = longint'(it.message_length);
                if (HDR + len > RING - 1)
                begin
                    r.status = ST_TOO_LONG;
                    return r;
                end
                if (HDR + len > ring_room())
                begin
                    r.status = ST_NO_ROOM;
                    refused_for_room++;
                    return r;
                end
                // Lay down the header from the committed point
                work_ptr = commit_ptr;
                for (int i = 0; i < HDR; i++)
                begin
                    ring_copy[work_ptr] = 8'(len >> (8 * i));
                    work_ptr = (work_ptr + 1) % RING;
                end
                if (len == 0)
                begin
                    commit_ptr = work_ptr;
                    r.last_of_message = 1'b1;
                    r.status = ST_WRITE_OK;
                    return r;
                end
                wr_left = int'(len);
            end
            ring_copy[work_ptr] = it.data_byte;
            work_ptr = (work_ptr + 1) % RING;
            wr_left--;
            if (wr_left == 0)
            begin
                commit_ptr = work_ptr;
                r.last_of_message = 1'b1;
            end
            r.status = ST_WRITE_OK;
        end
        else
        begin
            if (rd_left == 0)
            begin
                if (commit_ptr == rd_ptr)
                begin
                    r.status = ST_EMPTY;
                    return r;
                end
                len = header_at(rd_ptr);
                r.length_out = len[LEN_W-1:0];
                if (len > longint'(it.reader_limit))
                begin
                    r.status = ST_TOO_BIG;
                    return r;
                end
                rd_ptr = (rd_ptr + HDR) % RING;
                if (len == 0)
                begin
                    r.last_of_message = 1'b1;
                    r.status = ST_ZERO_LEN;
                    return r;
                end
                rd_left = int'(len);
            end
            r.data_byte_out = ring_copy[rd_ptr];
            rd_ptr = (rd_ptr + 1) % RING;
            rd_left--;
            if (rd_left == 0)
                r.last_of_message = 1'b1;
            r.status = ST_READ_OK;
        end
        return r;
    endfunction

    // Draw one random item; the mode biases the mix of writes, reads and lengths
    function automatic item_t pick_item(traffic_t mode);
        item_t it;
        int    r;
        int    pending_len;
        int    lo;
        it.data_byte      = 8'($urandom_range(0, 255));
        it.message_length = 12'($urandom_range(0, 4095));
        it.reader_limit   = 12'($urandom_range(0, 4095));
        r = $urandom_range(0, 99);
        case (mode)
            FILL_RING:  it.operation = (r < 98) ? OP_WRITE : OP_READ;
            DRAIN_RING: it.operation = (r < 4)  ? OP_WRITE : OP_READ;
            default:    it.operation = (r < 50) ? OP_WRITE : OP_READ;
        endcase
        r = $urandom_range(0, 99);
        if (it.operation == OP_WRITE && wr_left == 0)
        begin
            // Opening write: pick the message length
            if (mode != MIX_TRAFFIC)
                it.message_length = (r < 97) ? 12'd0 : 12'($urandom_range(1, 6));
            else if (r < 25)
                it.message_length = 12'd0;
            else if (r < 70)
                it.message_length = 12'($urandom_range(1, 12));
            else if (r < 84)
                it.message_length = 12'($urandom_range(13, 64));
            else if (r < 87)
                it.message_length = 12'($urandom_range(65, 120));
            else if (r < 94)
                it.message_length = 12'($urandom_range(RING - HDR, 4095));
            else
            begin
                lo = ring_room() - HDR + 1;
                if (lo < 0)
                    lo = 0;
                it.message_length = 12'($urandom_range(lo, 4095));
            end
        end
        else if (it.operation == OP_READ)
        begin
            // Opening read: mostly a limit that admits the message
            pending_len = next_read_length();
            if (pending_len >= 0)
            begin
                if (r < ((mode == MIX_TRAFFIC) ? 65 : 90))
                    it.reader_limit = 12'($urandom_range(pending_len, 4095));
                else if (r < ((mode == MIX_TRAFFIC) ? 85 : 95) && pending_len > 0)
                    it.reader_limit = 12'($urandom_range(0, pending_len - 1));
            end
        end
        return it;
    endfunction

    // Offer one item, wait for its transfer, then queue the expected result
    task automatic push_item(input item_t it, input logic typed, input result_t want);
        int      gap;
        result_t predicted;
        if (tx_gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.reader_limit, it.message_length, it.data_byte};
        s_axis_tuser  <= it.operation;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = ring_predict(it);
        awaited_results.push_back(typed ? want : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (awaited_results.size() != 0);
    endtask

    // Random traffic; fill stops after repeated room refusals, drain once empty
    task automatic run_traffic(input traffic_t mode, input int max_items);
        int n;
        int refusals_at_start;
        int reads_when_empty;
        bit done;
        n = 0;
        done = 1'b0;
        refusals_at_start = refused_for_room;
        reads_when_empty = 0;
        while (!done && n < max_items)
        begin
            if (n % 50 == 0 && !quiet_tail)
            begin
                tx_gaps_on = ($urandom_range(0, 3) != 0);
                rx_gaps_on = ($urandom_range(0, 3) != 0);
            end
            if (mode == MIX_TRAFFIC && n == max_items / 2)
                hold_until_drained();
            push_item(pick_item(mode), 1'b0, '0);
            n++;
            if (mode == FILL_RING && refused_for_room - refusals_at_start >= 3)
                done = 1'b1;
            if (mode == DRAIN_RING && commit_ptr == rd_ptr && rd_left == 0)
            begin
                reads_when_empty++;
                if (reads_when_empty >= 4)
                    done = 1'b1;
            end
        end
    endtask

    // Receiver: ready with random stall bursts
    initial
    begin : result_sink
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_gaps_on && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 11) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.data_byte_out   = m_axis_tdata[7:0];
            got.length_out      = m_axis_tdata[19:8];
            got.last_of_message = m_axis_tlast;
            got.status          = m_axis_tuser;
            status_tally[got.status]++;
            if (awaited_results.size() == 0)
            begin
                $error("result with nothing expected: status %0d", got.status);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.data_byte_out !== want.data_byte_out)
                begin
                    $error("data_byte_out: expected %0h, got %0h",
                           want.data_byte_out, got.data_byte_out);
                    mismatches++;
                end
                if (got.length_out !== want.length_out)
                begin
                    $error("length_out: expected %0d, got %0d", want.length_out, got.length_out);
                    mismatches++;
                end
                if (got.last_of_message !== want.last_of_message)
                begin
                    $error("last_of_message: expected %0b, got %0b",
                           want.last_of_message, got.last_of_message);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_WRITE;
        rst_n         = 1'b0;
        commit_ptr    = 0;
        work_ptr      = 0;
        rd_ptr        = 0;
        wr_left       = 0;
        rd_left       = 0;
        refused_for_room = 0;
        mismatches    = 0;
        items_sent    = 0;
        cycles        = 0;
        tx_gaps_on    = 1'b1;
        rx_gaps_on    = 1'b1;
        quiet_tail    = 1'b0;
        foreach (status_tally[i])
            status_tally[i] = 0;

        // Columns: op, byte, length, limit | given? | byte_out, last, length_out, status
        directed_plan = '{
            // read of an empty ring after reset
            {OP_READ,  8'h00, 12'h000, 12'h000, 1'b1, 8'h00, 1'b0, 12'h000, ST_EMPTY},
            // messages too long for the ring at all
            {OP_WRITE, 8'hFF, 12'hFFF, 12'h000, 1'b1, 8'h00, 1'b0, 12'h000, ST_TOO_LONG},
            {OP_WRITE, 8'h00, 12'hFF8, 12'hFFF, 1'b1, 8'h00, 1'b0, 12'h000, ST_TOO_LONG},
            // zero-length message: header only, committed at once
            {OP_WRITE, 8'hFF, 12'h000, 12'hFFF, 1'b1, 8'h00, 1'b1, 12'h000, ST_WRITE_OK},
            // one byte short of room
            {OP_WRITE, 8'h00, 12'hFF0, 12'h000, 1'b1, 8'h00, 1'b0, 12'h000, ST_NO_ROOM},
            // zero-length read
            {OP_READ,  8'hFF, 12'hFFF, 12'h000, 1'b1, 8'h00, 1'b1, 12'h000, ST_ZERO_LEN},
            {OP_READ,  8'h00, 12'h000, 12'hFFF, 1'b1, 8'h00, 1'b0, 12'h000, ST_EMPTY},
            // three-byte message, read attempted while it is still partial
            {OP_WRITE, 8'h00, 12'h003, 12'h000, 1'b0, 24'h0},
            {OP_READ,  8'h00, 12'h000, 12'h000, 1'b0, 24'h0},
            {OP_WRITE, 8'hFF, 12'hFFF, 12'h000, 1'b0, 24'h0},
            {OP_WRITE, 8'hA5, 12'h000, 12'h000, 1'b0, 24'h0},
            // too big for the reader, then a limit equal to the length
            {OP_READ,  8'h00, 12'h000, 12'h002, 1'b0, 24'h0},
            {OP_READ,  8'h00, 12'h000, 12'h003, 1'b0, 24'h0},
            // one-byte message written between reads of the first
            {OP_WRITE, 8'h5A, 12'h001, 12'h000, 1'b0, 24'h0},
            {OP_READ,  8'h00, 12'h000, 12'h000, 1'b0, 24'h0},
            {OP_READ,  8'h00, 12'h000, 12'hFFF, 1'b0, 24'h0},
            {OP_READ,  8'h00, 12'h000, 12'h001, 1'b0, 24'h0},
            {OP_READ,  8'h00, 12'h000, 12'h000, 1'b0, 24'h0}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_plan[i])
            push_item(directed_plan[i].it, directed_plan[i].typed, directed_plan[i].want);

        // Mixed traffic, fill to refusal, pause, drain to empty, then a gap-free tail
        run_traffic(MIX_TRAFFIC, 80);
        run_traffic(FILL_RING, 900);
        hold_until_drained();
        run_traffic(DRAIN_RING, 900);
        quiet_tail = 1'b1;
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_traffic(MIX_TRAFFIC, 50);
        s_axis_tvalid <= 1'b0;

        // Let the last results arrive, then allow for stragglers
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4 * HDR + 8) @(posedge clk);

        $display("Sent %0d items; results: write_ok %0d, read_ok %0d, empty %0d, too_big %0d",
                 items_sent, status_tally[ST_WRITE_OK], status_tally[ST_READ_OK],
                 status_tally[ST_EMPTY], status_tally[ST_TOO_BIG]);
        $display("  no_room %0d, too_long %0d, zero_length_read %0d; mismatches %0d",
                 status_tally[ST_NO_ROOM], status_tally[ST_TOO_LONG],
                 status_tally[ST_ZERO_LEN], mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
